### hdl/lsp_pkg.sv
package lsp_pkg;

	localparam int RL_W  = 8;
	localparam int RH_W  = 10;
	localparam int WGT_W = 4;
	localparam int OUT_W = RH_W + WGT_W;
	localparam int QW    = OUT_W;
	localparam int POS_W = 16;
	localparam int CMD_W = 2;
	localparam int IDX_W = 4;
	localparam int CFG_W = 10;
	localparam int SMP_W = 10;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_CAL   = 2'd1,
		CMD_LINE  = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_RANGE_LOW  = 1'b0,
		CFG_RANGE_HIGH = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic clear;
		logic update;
	} cal_ctl_t;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] quot;
	} div_rsp_t;

endpackage

### hdl/lsp_cal.sv
module lsp_cal #(
	parameter int SENSOR_COUNT = 10,
	parameter int SAMPLE_BITS  = 10,
	parameter int IW           = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lsp_pkg::cal_ctl_t      ctl,
	input  logic [IW-1:0]          wr_idx,
	input  logic [SAMPLE_BITS-1:0] smp,
	input  logic [IW-1:0]          rd_idx,
	output logic [SAMPLE_BITS-1:0] lo,
	output logic [SAMPLE_BITS-1:0] hi
);
	import lsp_pkg::*;

	logic [SAMPLE_BITS-1:0] min_q [SENSOR_COUNT];
	logic [SAMPLE_BITS-1:0] max_q [SENSOR_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SENSOR_COUNT; k++) begin
				min_q[k] <= '1;
				max_q[k] <= '0;
			end
		end else if (ctl.clear) begin
			for (int k = 0; k < SENSOR_COUNT; k++) begin
				min_q[k] <= '1;
				max_q[k] <= '0;
			end
		end else if (ctl.update) begin
			if (smp > max_q[wr_idx]) begin
				max_q[wr_idx] <= smp;
			end
			if (smp < min_q[wr_idx]) begin
				min_q[wr_idx] <= smp;
			end
		end
	end

	assign lo = min_q[rd_idx];
	assign hi = max_q[rd_idx];

endmodule

### hdl/lsp_div.sv
module lsp_div #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [SAMPLE_BITS+lsp_pkg::QW-1:0]   num,
	input  logic [SAMPLE_BITS-1:0]               den,
	output lsp_pkg::div_rsp_t                    rsp
);
	import lsp_pkg::*;

	localparam int NUM_W = SAMPLE_BITS + QW;
	localparam int CW    = $clog2(QW + 1);

	logic [SAMPLE_BITS-1:0] rem_q;
	logic [QW-1:0]          qb_q;
	logic [CW-1:0]          cnt_q;
	logic                   done_q;

	logic [SAMPLE_BITS:0]   t;
	logic [SAMPLE_BITS:0]   t_sub;
	logic                   ge;
	logic [SAMPLE_BITS-1:0] rem_n;

	assign t     = {rem_q, qb_q[QW-1]};
	assign ge    = t >= {1'b0, den};
	assign t_sub = t - {1'b0, den};
	assign rem_n = ge ? t_sub[SAMPLE_BITS-1:0] : t[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(QW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= cnt_q == CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// high part of the numerator is already below den: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:QW];
			qb_q  <= num[QW-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= rem_n;
			qb_q  <= {qb_q[QW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = qb_q;

endmodule

### hdl/line_sensor_position_top.sv
// Line sample: from acceptance to the next ready the word passes the prep and multiply steps,
// the bit-serial restoring divider (one quotient bit per cycle), its done cycle and the
// accumulate step, which stalls on the last sensor while an earlier result waits for
// out_ready; a new line word is taken only in idle. The result word of the last sensor turns
// valid in the same cycle as ready. Clear and calibration words do not leave idle. Async reset
// (arst_n low) clears calibration to min all ones / max zero, the scan sum and flag, range_low 0, range_high 100.
module line_sensor_position_top #(
	parameter int SENSOR_COUNT = 10,
	parameter int SAMPLE_BITS  = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [0:0]                           cfg_index,
	input  logic [lsp_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [lsp_pkg::CMD_W-1:0]            command,
	input  logic [lsp_pkg::IDX_W-1:0]            sensor_index,
	input  logic [lsp_pkg::SMP_W-1:0]            sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [lsp_pkg::POS_W-1:0]     position,
	output logic                                 uncalibrated
);
	import lsp_pkg::*;

	localparam int IW    = $clog2(SENSOR_COUNT);
	localparam int SB    = SAMPLE_BITS;
	localparam int NUM_W = SB + QW;
	localparam int HALF  = SENSOR_COUNT / 2;
	localparam int SUM_W = POS_W + 2;
	localparam logic [5:0]              NM1    = 6'(SENSOR_COUNT - 1);
	localparam logic [IW-1:0]           LAST   = IW'(SENSOR_COUNT - 1);
	localparam logic [IW-1:0]           LEFT_N = IW'(HALF);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

	state_t state_q, state_d;

	logic [RL_W-1:0]  range_low_q;
	logic [RH_W-1:0]  range_high_q;

	logic [IW-1:0]    idx_q;
	logic [SB-1:0]    samp_q;
	logic [SB-1:0]    xo_q;
	logic [SB-1:0]    den_q;
	logic [OUT_W-1:0] mag_q;
	logic             neg_q;
	logic             cur_uncal_q;

	logic signed [POS_W-1:0] acc_q;
	logic                    scan_uncal_q;
	logic                    out_valid_q;
	logic signed [POS_W-1:0] position_q;
	logic                    uncal_out_q;

	logic           in_fire;
	logic           idx_ok;
	logic [SB-1:0]  s_in;
	cal_ctl_t       cal_ctl;
	logic [SB-1:0]  lo, hi;
	logic           div_start;
	div_rsp_t       div_rsp;
	logic           acc_en;
	logic           fire_out;
	logic           is_last;
	logic           blocked;

	assign in_fire = in_valid && in_ready;
	assign idx_ok  = {1'b0, sensor_index} < (IDX_W + 1)'(SENSOR_COUNT);
	assign s_in    = SB'(sample);

	assign cal_ctl.clear  = in_fire && command == CMD_CLEAR;
	assign cal_ctl.update = in_fire && command == CMD_CAL && idx_ok;

	lsp_cal #(
		.SENSOR_COUNT(SENSOR_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS),
		.IW          (IW)
	) u_cal (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cal_ctl),
		.wr_idx(sensor_index[IW-1:0]),
		.smp   (s_in),
		.rd_idx(idx_q),
		.lo    (lo),
		.hi    (hi)
	);

	// prep: clamp, offsets and the per-sensor output span
	logic [SB-1:0]      x_cl;
	logic [5:0]         tw, ctr_ofs;
	logic [WGT_W-1:0]   weight;
	logic [OUT_W-1:0]   out_hi;
	logic signed [OUT_W:0] diff;
	logic [OUT_W:0]     ndiff;

	assign x_cl    = (samp_q < lo) ? lo : ((samp_q > hi) ? hi : samp_q);
	assign tw      = 6'({idx_q, 1'b0});
	assign ctr_ofs = (tw >= NM1) ? (tw - NM1) : (NM1 - tw);
	assign weight  = WGT_W'((ctr_ofs >> 1) + 6'd2);
	assign out_hi  = OUT_W'(range_high_q) * OUT_W'(weight);
	assign diff    = $signed({1'b0, out_hi}) - $signed((OUT_W + 1)'(range_low_q));
	assign ndiff   = -diff;

	logic [NUM_W-1:0] num;
	assign num = NUM_W'(xo_q) * NUM_W'(mag_q);

	lsp_div #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (den_q),
		.rsp   (div_rsp)
	);

	// accumulate with saturation
	logic signed [POS_W-1:0] v;
	logic signed [POS_W-1:0] rl_x, q_x;
	logic signed [SUM_W-1:0] sum;
	logic signed [POS_W-1:0] acc_n;

	assign rl_x = $signed(POS_W'(range_low_q));
	assign q_x  = $signed(POS_W'(div_rsp.quot));
	assign v    = cur_uncal_q ? rl_x : (neg_q ? rl_x - q_x : rl_x + q_x);
	assign sum  = (idx_q < LEFT_N) ? (SUM_W'(acc_q) + SUM_W'(v)) : (SUM_W'(acc_q) - SUM_W'(v));
	assign acc_n = (sum > SAT_HI) ? POS_W'(SAT_HI) :
	               (sum < SAT_LO) ? POS_W'(SAT_LO) : sum[POS_W-1:0];

	assign is_last  = idx_q == LAST;
	assign blocked  = is_last && out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		acc_en    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && command == CMD_LINE && idx_ok) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (!blocked) begin
					acc_en  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign fire_out = acc_en && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= RH_W'(100);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RANGE_LOW:  range_low_q  <= cfg_data[RL_W-1:0];
				CFG_RANGE_HIGH: range_high_q <= cfg_data[RH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			scan_uncal_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire_out) begin
				acc_q        <= '0;
				scan_uncal_q <= 1'b0;
			end else if (acc_en) begin
				acc_q        <= acc_n;
				scan_uncal_q <= scan_uncal_q | cur_uncal_q;
			end
			if (fire_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_q  <= sensor_index[IW-1:0];
			samp_q <= s_in;
		end
		if (state_q == ST_PREP) begin
			xo_q        <= x_cl - lo;
			den_q       <= hi - lo;
			cur_uncal_q <= hi <= lo;
			neg_q       <= diff[OUT_W];
			mag_q       <= diff[OUT_W] ? ndiff[OUT_W-1:0] : diff[OUT_W-1:0];
		end
		if (fire_out) begin
			position_q  <= acc_n;
			uncal_out_q <= scan_uncal_q | cur_uncal_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign position     = position_q;
	assign uncalibrated = uncal_out_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider done outside divide state");

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && command != CMD_LINE) |=> state_q == ST_IDLE)
		else $error("non-line word left idle state");

	a_scan_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire_out |=> (acc_q == '0) && !scan_uncal_q && out_valid)
		else $error("scan state not cleared after result");

endmodule
